@@ hdl/socc_pkg.sv @@
// ----------------------------------------------------------------------------
// socc_pkg
// Shared types and constants for the slot occupancy window classifier: beat
// payloads, configuration set, slot modes and controller command/status.
// ----------------------------------------------------------------------------
package socc_pkg;

	localparam int SLOTS_DEF  = 16;
	localparam int WINDOW_DEF = 20;

	localparam int RATIO_W = 9;
	localparam int BRIGHT_W = 8;
	localparam int HOLD_W = 16;
	localparam int SLOT_W = 4;
	localparam int MODE_W = 2;

	localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

	localparam logic [RATIO_W-1:0]  RATIO_THR_RST  = 9'd128;
	localparam logic [BRIGHT_W-1:0] HEAD_THR_RST   = 8'd95;
	localparam logic [HOLD_W-1:0]   OCC_HOLD_RST   = 16'd20;
	localparam logic [HOLD_W-1:0]   EXIT_HOLD_RST  = 16'd20;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_RATIO_THR = 2'd0,
		REG_HEAD_THR  = 2'd1,
		REG_OCC_HOLD  = 2'd2,
		REG_EXIT_HOLD = 2'd3
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_EMPTY    = 2'd0,
		MODE_OCCUPIED = 2'd1,
		MODE_EXITING  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_index;
		logic [RATIO_W-1:0]  overlap_ratio;
		logic [BRIGHT_W-1:0] brightness;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_echo;
		logic [MODE_W-1:0] slot_status;
		logic              status_changed;
		logic [HOLD_W-1:0] hold_value;
	} res_t;

	typedef struct packed {
		logic [RATIO_W-1:0]  ratio_threshold;
		logic [BRIGHT_W-1:0] lamp_threshold;
		logic [HOLD_W-1:0]   occupied_hold;
		logic [HOLD_W-1:0]   exiting_hold;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic slot_rd;
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic scan_last;
	} ctl_sts_t;

endpackage

@@ hdl/socc_regs.sv @@
// ----------------------------------------------------------------------------
// socc_regs
// APB-style configuration registers: thresholds and hold limits.
// ----------------------------------------------------------------------------
module socc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [socc_pkg::PADDR_W-1:0] paddr,
	input  logic [socc_pkg::PDATA_W-1:0] pwdata,
	output logic [socc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output socc_pkg::cfg_t               cfg
);
	import socc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio_threshold <= RATIO_THR_RST;
			cfg_q.lamp_threshold  <= HEAD_THR_RST;
			cfg_q.occupied_hold   <= OCC_HOLD_RST;
			cfg_q.exiting_hold    <= EXIT_HOLD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RATIO_THR: cfg_q.ratio_threshold <= pwdata[RATIO_W-1:0];
				REG_HEAD_THR:  cfg_q.lamp_threshold  <= pwdata[BRIGHT_W-1:0];
				REG_OCC_HOLD:  cfg_q.occupied_hold   <= pwdata[HOLD_W-1:0];
				REG_EXIT_HOLD: cfg_q.exiting_hold    <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_RATIO_THR: prdata = PDATA_W'(cfg_q.ratio_threshold);
			REG_HEAD_THR:  prdata = PDATA_W'(cfg_q.lamp_threshold);
			REG_OCC_HOLD:  prdata = PDATA_W'(cfg_q.occupied_hold);
			REG_EXIT_HOLD: prdata = PDATA_W'(cfg_q.exiting_hold);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ hdl/socc_ctrl.sv @@
// ----------------------------------------------------------------------------
// socc_ctrl
// Controller: sequences slot lookup, window update, window scan and the
// decision, and owns both handshakes.
// ----------------------------------------------------------------------------
module socc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  socc_pkg::ctl_sts_t   sts,
	output socc_pkg::ctl_cmd_t   cmd
);
	import socc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDSLOT,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   res_valid_q;
	logic   out_free;

	assign out_free   = !res_valid_q || res_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = item_valid;
				if (item_valid) state_nxt = ST_RDSLOT;
			end
			ST_RDSLOT: begin
				cmd.slot_rd = 1'b1;
				state_nxt   = sts.in_range ? ST_LOAD : ST_DECIDE;
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/socc_dp.sv @@
// ----------------------------------------------------------------------------
// socc_dp
// Datapath: per-slot state memory, window sample memory, peak scan and the
// three-mode slot decision with its result register.
// ----------------------------------------------------------------------------
module socc_dp #(
	parameter int SLOTS  = socc_pkg::SLOTS_DEF,
	parameter int WINDOW = socc_pkg::WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  socc_pkg::item_t    item,
	input  socc_pkg::cfg_t     cfg,
	input  socc_pkg::ctl_cmd_t cmd,
	output socc_pkg::ctl_sts_t sts,
	output socc_pkg::res_t     res
);
	import socc_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DEPTH = SLOTS * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int REC_W = MODE_W + HOLD_W + 1 + PW;
	localparam int WIN_W = RATIO_W + BRIGHT_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW - 1);

	item_t               item_q;
	logic [SW-1:0]       slot_a;
	logic                in_range;

	logic [REC_W-1:0]    slot_mem [SLOTS];
	logic [REC_W-1:0]    slot_rd_q;
	logic [SLOTS-1:0]    slot_vld_q;
	logic                rd_vld_q;
	logic [REC_W-1:0]    rec;

	logic [MODE_W-1:0]   mode_q;
	logic [HOLD_W-1:0]   hold_q;
	logic                wrap_q;
	logic [PW-1:0]       ptr_q;
	logic [AW-1:0]       base_q;
	logic [PW-1:0]       idx_q;

	logic [WIN_W-1:0]    win_mem [DEPTH];
	logic [WIN_W-1:0]    win_rd_s1;
	logic                rd_en_s1;
	logic                rd_ok_s1;
	logic [RATIO_W-1:0]  rmax_q;
	logic [BRIGHT_W-1:0] bmax_q;

	res_t                res_q;

	logic                free_slot;
	logic                dark;
	logic [HOLD_W-1:0]   hold_inc;
	logic [MODE_W-1:0]   mode_nxt;
	logic [HOLD_W-1:0]   hold_nxt;
	logic                ptr_end;
	logic [PW-1:0]       ptr_nxt;

	assign slot_a        = SW'(item_q.slot_index);
	assign in_range      = int'(item_q.slot_index) < SLOTS;
	assign sts.in_range  = in_range;
	assign sts.scan_last = (idx_q == PTR_LAST);
	assign res           = res_q;
	assign rec           = rd_vld_q ? slot_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.slot_rd) begin
			slot_rd_q <= slot_mem[slot_a];
			base_q    <= AW'(slot_a * WINDOW);
		end
		if (cmd.commit && in_range) begin
			slot_mem[slot_a] <= {mode_nxt, hold_nxt, wrap_q | ptr_end, ptr_nxt};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_mem[base_q + AW'(rec[PW-1:0])] <=
				{item_q.overlap_ratio, item_q.brightness};
		end
		if (cmd.scan) begin
			win_rd_s1 <= win_mem[base_q + AW'(idx_q)];
			rd_ok_s1  <= wrap_q || (idx_q <= ptr_q);
		end
		if (cmd.load) begin
			mode_q <= rec[REC_W-1 -: MODE_W];
			hold_q <= rec[PW+1 +: HOLD_W];
			wrap_q <= rec[PW];
			ptr_q  <= rec[PW-1:0];
			idx_q  <= '0;
			rmax_q <= '0;
			bmax_q <= '0;
		end else begin
			if (cmd.scan) idx_q <= idx_q + 1'b1;
			if (rd_en_s1 && rd_ok_s1) begin
				if (win_rd_s1[WIN_W-1 -: RATIO_W] > rmax_q) begin
					rmax_q <= win_rd_s1[WIN_W-1 -: RATIO_W];
				end
				if (win_rd_s1[BRIGHT_W-1:0] > bmax_q) begin
					bmax_q <= win_rd_s1[BRIGHT_W-1:0];
				end
			end
		end
		if (cmd.commit) begin
			res_q.slot_echo <= item_q.slot_index;
			if (in_range) begin
				res_q.slot_status    <= mode_nxt;
				res_q.status_changed <= (mode_nxt != mode_q);
				res_q.hold_value     <= hold_nxt;
			end else begin
				res_q.slot_status    <= '0;
				res_q.status_changed <= 1'b0;
				res_q.hold_value     <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rd_vld_q   <= 1'b0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan;
			if (cmd.slot_rd) rd_vld_q <= slot_vld_q[slot_a];
			if (cmd.commit && in_range) slot_vld_q[slot_a] <= 1'b1;
		end
	end

	assign free_slot = (rmax_q <= cfg.ratio_threshold);
	assign dark      = (bmax_q <= cfg.lamp_threshold);
	assign hold_inc  = (hold_q == HOLD_MAX) ? hold_q : hold_q + 1'b1;
	assign ptr_end   = (ptr_q == PTR_LAST);
	assign ptr_nxt   = ptr_end ? '0 : ptr_q + 1'b1;

	always_comb begin
		mode_nxt = mode_q;
		hold_nxt = hold_q;
		unique case (mode_q)
			MODE_EMPTY: begin
				if (!free_slot) mode_nxt = MODE_OCCUPIED;
			end
			MODE_OCCUPIED: begin
				priority if (free_slot) begin
					mode_nxt = MODE_EMPTY;
					hold_nxt = '0;
				end else if (dark || (hold_q >= cfg.occupied_hold)) begin
					hold_nxt = hold_inc;
				end else begin
					mode_nxt = MODE_EXITING;
					hold_nxt = '0;
				end
			end
			MODE_EXITING: begin
				priority if (free_slot) begin
					mode_nxt = MODE_EMPTY;
					hold_nxt = '0;
				end else if (dark && (hold_q >= cfg.exiting_hold)) begin
					mode_nxt = MODE_OCCUPIED;
					hold_nxt = '0;
				end else if (dark) begin
					hold_nxt = hold_inc;
				end else begin
					hold_nxt = '0;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/slot_occupancy_window_classifier.sv @@
// ----------------------------------------------------------------------------
// slot_occupancy_window_classifier
// Sequence: slot lookup, window update, window scan, then the decision, which waits
// until the output register is free; a new beat is taken only back in idle.
// The window scan reads one sample per cycle from the window memory.
// Reset: no clearing pass; per-slot valid bits and the write pointer make
// unwritten slots and window entries read as zero, so the block is ready at once.
// ----------------------------------------------------------------------------
module slot_occupancy_window_classifier #(
	parameter int SLOTS  = socc_pkg::SLOTS_DEF,
	parameter int WINDOW = socc_pkg::WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  socc_pkg::item_t              item_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output socc_pkg::res_t               res_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [socc_pkg::PADDR_W-1:0] paddr,
	input  logic [socc_pkg::PDATA_W-1:0] pwdata,
	output logic [socc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import socc_pkg::*;

	cfg_t     cfg;
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	socc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	socc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	socc_dp #(
		.SLOTS  (SLOTS),
		.WINDOW (WINDOW)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_data),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res_data)
	);

endmodule

@@ tb/slot_occupancy_window_classifier_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_occupancy_window_classifier_tb
// Sends measurement beats for all sixteen slots and keeps its own copy of each
// slot's windows, state and hold count to predict every result beat. The
// thresholds are changed between phases through the register port and read
// back. The phases cycle through four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module slot_occupancy_window_classifier_tb;
	import socc_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int WINDOW = WINDOW_DEF;
	localparam int LATENCY = WINDOW + 4;
	localparam int PHASES = 8;
	localparam int ITEM_W = $bits(item_t);

	class slot_state_tracker;
		logic [RATIO_W-1:0]  ratio_hist [SLOTS][WINDOW];
		logic [BRIGHT_W-1:0] bright_hist [SLOTS][WINDOW];
		int unsigned         wr_pos [SLOTS];
		mode_t               slot_mode [SLOTS];
		logic [HOLD_W-1:0]   hold [SLOTS];
		cfg_t                cfg;
		res_t                status_due [$];
		int unsigned         faults;
		int unsigned         beats_checked;
		int unsigned         mode_seen [3];
		int unsigned         changes;

		function new();
			foreach (ratio_hist[s, i]) begin
				ratio_hist[s][i] = '0;
				bright_hist[s][i] = '0;
			end
			foreach (wr_pos[s]) begin
				wr_pos[s] = 0;
				slot_mode[s] = MODE_EMPTY;
				hold[s] = '0;
			end
			foreach (mode_seen[m]) mode_seen[m] = 0;
			cfg.ratio_threshold = RATIO_THR_RST;
			cfg.lamp_threshold = HEAD_THR_RST;
			cfg.occupied_hold = OCC_HOLD_RST;
			cfg.exiting_hold = EXIT_HOLD_RST;
			faults = 0;
			beats_checked = 0;
			changes = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [31:0] value);
			case (idx)
			REG_RATIO_THR: cfg.ratio_threshold = value[RATIO_W-1:0];
			REG_HEAD_THR:  cfg.lamp_threshold = value[BRIGHT_W-1:0];
			REG_OCC_HOLD:  cfg.occupied_hold = value[HOLD_W-1:0];
			default:       cfg.exiting_hold = value[HOLD_W-1:0];
			endcase
		endfunction

		function logic [31:0] register_value(reg_idx_t idx);
			case (idx)
			REG_RATIO_THR: return 32'(cfg.ratio_threshold);
			REG_HEAD_THR:  return 32'(cfg.lamp_threshold);
			REG_OCC_HOLD:  return 32'(cfg.occupied_hold);
			default:       return 32'(cfg.exiting_hold);
			endcase
		endfunction

		function void fault(string msg);
			faults++;
			if (faults <= 10) $display("mismatch: %s", msg);
		endfunction

		function logic [HOLD_W-1:0] sat_bump(logic [HOLD_W-1:0] v);
			return (v == HOLD_MAX) ? v : v + 1'b1;
		endfunction

		function void note_measurement(item_t it);
			int unsigned         s;
			logic [RATIO_W-1:0]  r_peak;
			logic [BRIGHT_W-1:0] b_peak;
			logic                vacant;
			logic                dark;
			mode_t               nxt;
			logic [HOLD_W-1:0]   cnt;
			res_t                want;
			s = 32'(it.slot_index);
			ratio_hist[s][wr_pos[s]] = it.overlap_ratio;
			bright_hist[s][wr_pos[s]] = it.brightness;
			wr_pos[s] = (wr_pos[s] + 1) % WINDOW;
			r_peak = '0;
			b_peak = '0;
			for (int i = 0; i < WINDOW; i++) begin
				if (ratio_hist[s][i] > r_peak) r_peak = ratio_hist[s][i];
				if (bright_hist[s][i] > b_peak) b_peak = bright_hist[s][i];
			end
			vacant = r_peak <= cfg.ratio_threshold;
			dark = b_peak <= cfg.lamp_threshold;
			nxt = slot_mode[s];
			cnt = hold[s];
			case (slot_mode[s])
			MODE_EMPTY: begin
				if (!vacant) nxt = MODE_OCCUPIED;
			end
			MODE_OCCUPIED: begin
				if (vacant) begin
					nxt = MODE_EMPTY;
					cnt = '0;
				end else if (dark || cnt >= cfg.occupied_hold) begin
					cnt = sat_bump(cnt);
				end else begin
					nxt = MODE_EXITING;
					cnt = '0;
				end
			end
			MODE_EXITING: begin
				if (vacant) begin
					nxt = MODE_EMPTY;
					cnt = '0;
				end else if (!dark) begin
					cnt = '0;
				end else if (cnt >= cfg.exiting_hold) begin
					nxt = MODE_OCCUPIED;
					cnt = '0;
				end else begin
					cnt = sat_bump(cnt);
				end
			end
			default: ;
			endcase
			want.slot_echo = it.slot_index;
			want.slot_status = nxt;
			want.status_changed = (nxt != slot_mode[s]);
			want.hold_value = cnt;
			mode_seen[nxt]++;
			if (want.status_changed) changes++;
			slot_mode[s] = nxt;
			hold[s] = cnt;
			status_due = {status_due, want};
		endfunction

		function void check_status(res_t got);
			res_t want;
			if (status_due.size() == 0) begin
				fault($sformatf("result beat for slot %0d with nothing expected", got.slot_echo));
				return;
			end
			want = status_due[0];
			status_due.delete(0);
			beats_checked++;
			if (got.slot_echo !== want.slot_echo)
				fault($sformatf("slot_echo expected %0d, got %0d",
					want.slot_echo, got.slot_echo));
			if (got.slot_status !== want.slot_status)
				fault($sformatf("slot %0d slot_status expected %0d, got %0d",
					want.slot_echo, want.slot_status, got.slot_status));
			if (got.status_changed !== want.status_changed)
				fault($sformatf("slot %0d status_changed expected %0d, got %0d",
					want.slot_echo, want.status_changed, got.status_changed));
			if (got.hold_value !== want.hold_value)
				fault($sformatf("slot %0d hold_value expected %0d, got %0d",
					want.slot_echo, want.hold_value, got.hold_value));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	item_t              item_data;
	logic               res_valid;
	logic               res_ready;
	res_t               res_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	slot_state_tracker tracker;
	int unsigned       send_idle_pct;
	int unsigned       recv_stall_pct;
	int unsigned       hold_off_req;
	int unsigned       items_sent;
	int unsigned       settings_used;
	int unsigned       phase_share [PHASES] = '{300, 260, 260, 260, 120, 260, 250, 240};

	slot_occupancy_window_classifier dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin : receiver
		int unsigned hold_left;
		if (hold_off_req != 0) begin
			hold_left = hold_off_req;
			hold_off_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) tracker.check_status(res_data);
	end

	task automatic send_measurement(item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (!item_ready);
		tracker.note_measurement(it);
		items_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (tracker.status_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic program_register(reg_idx_t idx, logic [31:0] value);
		int unsigned width;
		width = (idx == REG_RATIO_THR) ? RATIO_W : (idx == REG_HEAD_THR) ? BRIGHT_W : HOLD_W;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value | ($urandom() << width);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(idx, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tracker.register_value(idx))
			tracker.fault($sformatf("register %s read back %0h, expected %0h",
				idx.name(), prdata, tracker.register_value(idx)));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int p);
		logic [8:0]  r;
		logic [7:0]  h;
		logic [15:0] oh;
		logic [15:0] eh;
		case (p)
		1:       {r, h, oh, eh} = {9'd0, 8'd0, 16'd0, 16'd0};
		2:       {r, h, oh, eh} = {9'd256, 8'd255, 16'hFFFF, 16'hFFFF};
		3:       {r, h, oh, eh} = {9'd100, 8'd60, 16'd4, 16'd3};
		4:       {r, h, oh, eh} = {9'd511, 8'd128, 16'hFFFF, 16'd0};
		5:       {r, h, oh, eh} = {9'd200, 8'd30, 16'd10, 16'd6};
		6:       {r, h, oh, eh} = {9'd64, 8'd150, 16'd2, 16'd1};
		default: {r, h, oh, eh} = {9'd128, 8'd95, 16'd20, 16'd20};
		endcase
		drain_results();
		program_register(REG_RATIO_THR, 32'(r));
		program_register(REG_HEAD_THR, 32'(h));
		program_register(REG_OCC_HOLD, 32'(oh));
		program_register(REG_EXIT_HOLD, 32'(eh));
		settings_used++;
	endtask

	function automatic item_t measurement(int unsigned s, bit present, bit lit);
		item_t       it;
		int unsigned lo;
		it.slot_index = s[SLOT_W-1:0];
		lo = tracker.cfg.ratio_threshold + 1;
		if (!present)
			it.overlap_ratio = RATIO_W'($urandom_range(tracker.cfg.ratio_threshold, 0));
		else if (lo > 511) it.overlap_ratio = RATIO_W'($urandom_range(511, 0));
		else if (lo <= 256 && $urandom_range(7) != 0)
			it.overlap_ratio = RATIO_W'($urandom_range(256, lo));
		else it.overlap_ratio = RATIO_W'($urandom_range(511, lo));
		lo = tracker.cfg.lamp_threshold + 1;
		if (!lit) it.brightness = BRIGHT_W'($urandom_range(tracker.cfg.lamp_threshold, 0));
		else if (lo > 255) it.brightness = BRIGHT_W'($urandom_range(255, 0));
		else it.brightness = BRIGHT_W'($urandom_range(255, lo));
		return it;
	endfunction

	task automatic run_episode();
		int unsigned s;
		int unsigned k;
		item_t       noise;
		s = $urandom_range(SLOTS - 1);
		k = $urandom_range(9);
		if (k < 2) begin
			repeat ($urandom_range(8, 1)) begin
				noise = ITEM_W'($urandom());
				send_measurement(noise);
			end
		end else if (k < 5) begin
			repeat ($urandom_range(40, 5))
				send_measurement(measurement(s, 1'b1, $urandom_range(7) == 0));
		end else if (k < 7) begin
			repeat ($urandom_range(4, 1)) send_measurement(measurement(s, 1'b1, 1'b1));
			repeat ($urandom_range(45, 10)) send_measurement(measurement(s, 1'b1, 1'b0));
		end else if (k < 9) begin
			repeat ($urandom_range(WINDOW + 4, 15))
				send_measurement(measurement(s, 1'b0, 1'($urandom_range(1))));
		end else begin
			repeat ($urandom_range(12, 3))
				send_measurement(measurement(s, 1'($urandom_range(1)),
					1'($urandom_range(1))));
		end
	endtask

	task automatic run_directed();
		item_t seq [12];
		seq = '{'{4'd0, 9'd256, 8'd0}, '{4'd0, 9'd511, 8'd255}, '{4'd0, 9'd0, 8'd0},
			'{4'd15, 9'd0, 8'd255}, '{4'd15, 9'd129, 8'd96}, '{4'd15, 9'd128, 8'd95},
			'{4'd7, 9'd200, 8'd10}, '{4'd7, 9'd200, 8'd95}, '{4'd7, 9'd300, 8'd50},
			'{4'd8, 9'd128, 8'd0}, '{4'd8, 9'd1, 8'd255}, '{4'd3, 9'd257, 8'd0}};
		foreach (seq[i]) send_measurement(seq[i]);
	endtask

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned goal;
		int unsigned half;
		bit          pressed;
		tracker = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 0;
		items_sent = 0;
		settings_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		goal = 0;
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) apply_setting(p);
			case (p % 4)
			0:       {send_idle_pct, recv_stall_pct} = {32'd0, 32'd0};
			1:       {send_idle_pct, recv_stall_pct} = {32'd58, 32'd0};
			2:       {send_idle_pct, recv_stall_pct} = {32'd0, 32'd58};
			default: {send_idle_pct, recv_stall_pct} = {32'd19, 32'd19};
			endcase
			goal += phase_share[p];
			half = goal - phase_share[p] / 2;
			pressed = 1'b0;
			while (items_sent < goal) begin
				run_episode();
				if (!pressed && items_sent >= half) begin
					pressed = 1'b1;
					if (p == 2) hold_off_req = 400;
					if (p == 5) drain_results();
				end
			end
		end
		drain_results();
		$display("%0d measurement beats over %0d threshold settings, %0d result beats checked",
			items_sent, settings_used, tracker.beats_checked);
		$display("results: %0d empty, %0d occupied, %0d exiting, %0d state changes, %0d mismatches",
			tracker.mode_seen[MODE_EMPTY], tracker.mode_seen[MODE_OCCUPIED],
			tracker.mode_seen[MODE_EXITING], tracker.changes, tracker.faults);
		if (tracker.faults == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/socc_pkg.sv
hdl/socc_regs.sv
hdl/socc_ctrl.sv
hdl/socc_dp.sv
hdl/slot_occupancy_window_classifier.sv
tb/slot_occupancy_window_classifier_tb.sv
